// ===== rtl/first_fit_block_allocator_defines.svh =====
// Assertion macros used by the allocator's port-level checker.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define FFBA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ffba check failed");

// Next-cycle implication, reset masks the check.
`define FFBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ffba check failed");

`endif

// ===== rtl/ffba_pkg.sv =====
// Types and constants of the first-fit block allocator.
package ffba_pkg;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_ZERO    = 3'd1;
   localparam logic [2:0] STATUS_NOMEM   = 3'd2;
   localparam logic [2:0] STATUS_NULL    = 3'd3;
   localparam logic [2:0] STATUS_UNKNOWN = 3'd4;

   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEAP_BASE   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEAP_LIMIT  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEADER_SIZE = 2'd2;

   localparam logic [31:0] HEAP_BASE_RST   = 32'd65536;
   localparam logic [31:0] HEAP_LIMIT_RST  = 32'd1048576;
   localparam logic [7:0]  HEADER_SIZE_RST = 8'd24;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic        opcode;
      logic [31:0] request_size;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic [31:0] payload_address;
      logic [2:0]  status;
   } rsp_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic search;     // capture first-fit select
      logic op_free;    // match on address, not on size
      logic addr_fits;  // address lies inside the address space
      logic set_free;   // selected cell becomes free
      logic take;       // selected cell is reused
      logic append;     // tail cell gets the new block
   } cell_ctl_type;

endpackage

// ===== rtl/ffba_cell.sv =====
// One table entry of the allocator with its link in the first-fit chain.
module ffba_cell #(
   parameter int INDEX    = 0,
   parameter int CNT_BITS = 7,
   parameter int CMP_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ffba_pkg::cell_ctl_type  ctl,
   input  logic [CNT_BITS-1:0]     count,
   input  logic [31:0]             req_size,
   input  logic [CMP_BITS-1:0]     key,
   input  logic [CMP_BITS-1:0]     top_offset,
   input  logic                    found_in,
   output logic                    found_out,
   output logic [CMP_BITS-1:0]     sel_offset
);

   logic [31:0]         size_ff;
   logic [CMP_BITS-1:0] off_ff;
   logic                free_ff;
   logic                sel_ff;
   logic                valid;
   logic                tail;
   logic                hit;

   assign valid = count > CNT_BITS'(INDEX);
   assign tail  = count == CNT_BITS'(INDEX);

   always_comb begin
      if (ctl.op_free) begin
         hit = valid && ctl.addr_fits && (off_ff == key);
      end else begin
         hit = valid && free_ff && (size_ff >= req_size);
      end
   end

   assign found_out  = found_in | hit;
   assign sel_offset = sel_ff ? off_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else if (ctl.search) begin
         sel_ff <= hit & ~found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.append && tail) begin
         size_ff <= req_size;
         off_ff  <= top_offset;
         free_ff <= 1'b0;
      end else if (ctl.set_free && sel_ff) begin
         free_ff <= 1'b1;
      end else if (ctl.take && sel_ff) begin
         free_ff <= 1'b0;
      end
   end

endmodule

// ===== rtl/first_fit_block_allocator.sv =====
// Top level of the first-fit heap block allocator.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    ffba_pkg::req_type  (opcode, size, address)
//   rsp      out        rsp_valid/stall    ffba_pkg::rsp_type  (payload address, status)
//   csr      in         csr_valid/ready    csr_index, csr_data (base, limit, header)
//
// An accepted request is searched in the match state and its response is
// registered as the commit state finishes, where the next request may
// already be accepted, and not before. Reset clears state, response valid,
// block count, heap top and cell selects and loads the config defaults;
// table entries at or above the count are never read, so need no clearing pass.
// A stalled response holds the block in its update cycle until it drains.
module first_fit_block_allocator #(
   parameter int MAX_BLOCKS = 64,
   parameter int ADDR_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ffba_pkg::req_type                   req,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ffba_pkg::rsp_type                   rsp,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ffba_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [31:0]                         csr_data
);

   // Addresses wrap at the smaller of the address space and the 32-bit field.
   localparam int CMP_BITS = (ADDR_BITS < 32) ? ADDR_BITS : 32;
   localparam int CNT_BITS = $clog2(MAX_BLOCKS + 1);

   // Control state
   ffba_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [31:0]         top_ff, top_in;
   logic [31:0]         heap_base_ff;
   logic [31:0]         heap_limit_ff;
   logic [7:0]          header_size_ff;

   // Request held for the search and update cycles
   ffba_pkg::req_type   req_ff;
   logic [CMP_BITS-1:0] key_ff;       // address minus base and header
   logic                fits_ff;      // address reachable at all
   logic                zero_ff;      // allocate of zero bytes
   logic                null_ff;      // free of the null address
   logic [31:0]         base_hdr_ff;  // base plus header, payload origin
   logic [32:0]         need_ff;      // header plus request size

   // Search results
   logic                found_ff;
   logic                nomem_ff;
   logic [31:0]         newtop_ff;

   ffba_pkg::rsp_type   rsp_ff, rsp_in;

   logic                    req_accept;
   logic                    commit_go;
   ffba_pkg::cell_ctl_type  ctl;
   logic [MAX_BLOCKS:0]     found_chain;
   logic [CMP_BITS-1:0]     cell_off [MAX_BLOCKS];
   logic [CMP_BITS-1:0]     sel_off;
   logic [31:0]             reuse_addr;
   logic [31:0]             new_addr;
   logic [33:0]             top_sum;

   assign csr_ready = 1'b1;

   // Update cycle may finish when the response register is free or draining.
   assign commit_go  = (state_ff == ffba_pkg::ST_COMMIT) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = !((state_ff == ffba_pkg::ST_IDLE) || commit_go);
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // ---------------------------------------------------------------- cells
   assign found_chain[0] = 1'b0;

   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      ffba_cell #(
         .INDEX    (i),
         .CNT_BITS (CNT_BITS),
         .CMP_BITS (CMP_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .count      (count_ff),
         .req_size   (req_ff.request_size),
         .key        (key_ff),
         .top_offset (top_ff[CMP_BITS-1:0]),
         .found_in   (found_chain[i]),
         .found_out  (found_chain[i+1]),
         .sel_offset (cell_off[i])
      );
   end

   // At most one cell is selected, so an OR picks its offset.
   always_comb begin
      sel_off = '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         sel_off = sel_off | cell_off[i];
      end
   end

   assign reuse_addr = base_hdr_ff + 32'(sel_off);
   assign new_addr   = base_hdr_ff + 32'(top_ff[CMP_BITS-1:0]);
   assign top_sum    = {2'b00, top_ff} + {1'b0, need_ff};

   // ------------------------------------------------------ state machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffba_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         top_ff       <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         top_ff   <= top_in;
         if (commit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      rsp_in       = rsp_ff;
      ctl          = '0;
      ctl.op_free  = req_ff.opcode == ffba_pkg::OP_FREE;
      ctl.addr_fits = fits_ff;

      case (state_ff)
         ffba_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = ffba_pkg::ST_MATCH;
            end
         end
         ffba_pkg::ST_MATCH: begin
            ctl.search = 1'b1;
            state_in   = ffba_pkg::ST_COMMIT;
         end
         ffba_pkg::ST_COMMIT: begin
            if (commit_go) begin
               state_in = req_accept ? ffba_pkg::ST_MATCH : ffba_pkg::ST_IDLE;
               rsp_in.payload_address = '0;
               rsp_in.status          = ffba_pkg::STATUS_OK;
               if (req_ff.opcode == ffba_pkg::OP_ALLOC) begin
                  if (zero_ff) begin
                     rsp_in.status = ffba_pkg::STATUS_ZERO;
                  end else if (found_ff) begin
                     ctl.take = 1'b1;
                     rsp_in.payload_address = 32'(reuse_addr[CMP_BITS-1:0]);
                  end else if (nomem_ff) begin
                     rsp_in.status = ffba_pkg::STATUS_NOMEM;
                  end else begin
                     ctl.append = 1'b1;
                     count_in   = count_ff + CNT_BITS'(1);
                     top_in     = newtop_ff;
                     rsp_in.payload_address = 32'(new_addr[CMP_BITS-1:0]);
                  end
               end else begin
                  if (null_ff) begin
                     rsp_in.status = ffba_pkg::STATUS_NULL;
                  end else if (found_ff) begin
                     ctl.set_free = 1'b1;
                  end else begin
                     rsp_in.status = ffba_pkg::STATUS_UNKNOWN;
                  end
               end
            end
         end
         default: begin
            state_in = ffba_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------- datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff      <= req;
         key_ff      <= CMP_BITS'(req.address - heap_base_ff - 32'(header_size_ff));
         fits_ff     <= (req.address >> CMP_BITS) == '0;
         zero_ff     <= req.request_size == '0;
         null_ff     <= req.address == '0;
         base_hdr_ff <= heap_base_ff + 32'(header_size_ff);
         need_ff     <= 33'(header_size_ff) + 33'(req.request_size);
      end
      if (state_ff == ffba_pkg::ST_MATCH) begin
         found_ff  <= found_chain[MAX_BLOCKS];
         nomem_ff  <= (count_ff == CNT_BITS'(MAX_BLOCKS)) || (top_sum > 34'(heap_limit_ff));
         newtop_ff <= top_sum[31:0];
      end
      if (commit_go) begin
         rsp_ff <= rsp_in;
      end
   end

   // -------------------------------------------------- config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff   <= ffba_pkg::HEAP_BASE_RST;
         heap_limit_ff  <= ffba_pkg::HEAP_LIMIT_RST;
         header_size_ff <= ffba_pkg::HEADER_SIZE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ffba_pkg::CSR_HEAP_BASE: begin
               heap_base_ff <= csr_data;
            end
            ffba_pkg::CSR_HEAP_LIMIT: begin
               heap_limit_ff <= csr_data;
            end
            ffba_pkg::CSR_HEADER_SIZE: begin
               header_size_ff <= csr_data[7:0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== rtl/ffba_checker.sv =====
// Port-level checks of the allocator, bound to the top level.
`include "first_fit_block_allocator_defines.svh"

module ffba_sva (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ffba_pkg::rsp_type rsp
);

   logic req_accept;

   assign req_accept = req_valid && !req_stall;

   // The match state stalls requests, so back-to-back accepts cannot occur.
   `FFBA_ASSERT_NEXT(a_no_double_accept, clock, reset, req_accept, req_stall)

   // A failed request never hands out an address.
   `FFBA_ASSERT_NOW(a_fail_no_addr, clock, reset,
      rsp_valid && (rsp.status != ffba_pkg::STATUS_OK), rsp.payload_address == '0)

   `FFBA_ASSERT_NOW(a_status_range, clock, reset, rsp_valid,
      (rsp.status == ffba_pkg::STATUS_OK) || (rsp.status == ffba_pkg::STATUS_ZERO) ||
      (rsp.status == ffba_pkg::STATUS_NOMEM) || (rsp.status == ffba_pkg::STATUS_NULL) ||
      (rsp.status == ffba_pkg::STATUS_UNKNOWN))

   `FFBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp))

   `FFBA_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind first_fit_block_allocator ffba_sva u_ffba_sva (.*);

// ===== tb/ffba_checker.sv =====
// Response checker for the first-fit block allocator: tracks the heap and compares each response.
module ffba_checker
   import ffba_pkg::*;
#(
   parameter int MAX_BLOCKS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  req_type           req,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rsp_type           rsp,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [31:0]       csr_data,
   output int                fail_count,
   output int                outstanding
);

   // mirror of the register file
   logic [31:0] cfg_base;
   logic [31:0] cfg_limit;
   logic [7:0]  cfg_hdr;

   // mirror of the block table
   logic [31:0] blk_size [MAX_BLOCKS];
   logic [31:0] blk_off  [MAX_BLOCKS];
   logic        blk_free [MAX_BLOCKS];
   int          n_blocks;
   logic [31:0] heap_used;

   rsp_type awaited_rsp[$];
   int      mismatches;

   initial begin
      fail_count  = 0;
      outstanding = 0;
      mismatches  = 0;
   end

   function automatic logic [31:0] payload_at(int idx);
      return cfg_base + blk_off[idx] + {24'd0, cfg_hdr};
   endfunction

   // Applies one request to the mirrored heap and returns the response it earns.
   function automatic rsp_type apply_heap_request(req_type r);
      rsp_type     o;
      logic [63:0] need;
      int          hit;
      o.payload_address = '0;
      o.status          = STATUS_OK;
      hit               = -1;
      if (r.opcode == OP_ALLOC) begin
         if (r.request_size == '0) begin
            o.status = STATUS_ZERO;
         end else begin
            for (int i = 0; i < n_blocks; i++)
               if (hit < 0 && blk_free[i] && blk_size[i] >= r.request_size) hit = i;
            if (hit >= 0) begin
               blk_free[hit]     = 1'b0;
               o.payload_address = payload_at(hit);
            end else if (n_blocks >= MAX_BLOCKS) begin
               o.status = STATUS_NOMEM;
            end else begin
               need = 64'(heap_used) + 64'(cfg_hdr) + 64'(r.request_size);
               if (need > 64'(cfg_limit)) begin
                  o.status = STATUS_NOMEM;
               end else begin
                  blk_size[n_blocks] = r.request_size;
                  blk_off[n_blocks]  = heap_used;
                  blk_free[n_blocks] = 1'b0;
                  o.payload_address  = payload_at(n_blocks);
                  n_blocks++;
                  heap_used = need[31:0];
               end
            end
         end
      end else begin
         if (r.address == '0) begin
            o.status = STATUS_NULL;
         end else begin
            for (int i = 0; i < n_blocks; i++)
               if (hit < 0 && payload_at(i) == r.address) hit = i;
            if (hit >= 0) blk_free[hit] = 1'b1;
            else o.status = STATUS_UNKNOWN;
         end
      end
      return o;
   endfunction

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected addr %h status %0d, got addr %h status %0d",
                  $realtime, what, want.payload_address, want.status,
                  got.payload_address, got.status);
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         cfg_base  = HEAP_BASE_RST;
         cfg_limit = HEAP_LIMIT_RST;
         cfg_hdr   = HEADER_SIZE_RST;
         n_blocks  = 0;
         heap_used = '0;
         awaited_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HEAP_BASE:   cfg_base  = csr_data;
               CSR_HEAP_LIMIT:  cfg_limit = csr_data;
               CSR_HEADER_SIZE: cfg_hdr   = csr_data[7:0];
               default: ;
            endcase
         end
         // responses first: a request accepted now cannot be answered at this edge
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               want = '0;
               note_mismatch("response with none outstanding", want, rsp);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp.payload_address !== want.payload_address ||
                   rsp.status !== want.status)
                  note_mismatch("response mismatch", want, rsp);
            end
         end
         if (req_valid && !req_stall) awaited_rsp.push_back(apply_heap_request(req));
      end
      outstanding <= awaited_rsp.size();
      fail_count  <= mismatches;
   end

endmodule

// ===== tb/tb_first_fit_block_allocator.sv =====
// Testbench top for the first-fit block allocator: clock, reset, stimulus and verdict.
module tb_first_fit_block_allocator;
   import ffba_pkg::*;

   localparam int MAX_BLOCKS  = 64;
   localparam int PHASE_ITEMS = 170;
   localparam int CYCLE_LIMIT = 150000;
   // index past the register list; a write there must be dropped
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req       = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [31:0]             csr_data  = '0;

   int fail_count;
   int outstanding;
   int cycles = 0;

   // idling control: quiet turns all idling off for the closing phase,
   // the calm flags give stretches without idling on each side
   bit quiet     = 1'b0;
   bit send_calm = 1'b0;
   bit recv_calm = 1'b0;
   int stall_left = 0;

   // payload addresses granted in the current setting, used to aim frees
   logic [31:0] granted_addrs[$];

   first_fit_block_allocator #(
      .MAX_BLOCKS(MAX_BLOCKS),
      .ADDR_BITS (32)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req      (req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp      (rsp),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   ffba_checker #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req        (req),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .outstanding(outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Response side back-pressure in random stall bursts.
   always @(posedge clock) begin
      if ($urandom_range(0, 24) == 0) recv_calm = !recv_calm;
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left = stall_left - 1;
      end else if (!recv_calm && $urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Collect granted addresses so that most frees hit a live block.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall && rsp.status == STATUS_OK &&
          rsp.payload_address != '0) begin
         granted_addrs.push_back(rsp.payload_address);
         if (granted_addrs.size() > 2 * MAX_BLOCKS) void'(granted_addrs.pop_front());
      end
   end

   // Present one request and hold it until accepted. Valid stays high on
   // return so back-to-back requests keep it high unless an idle gap is drawn.
   task automatic issue(input logic op, input logic [31:0] size, input logic [31:0] addr);
      int gap;
      if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
      if (!quiet && !send_calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= '{opcode: op, request_size: size, address: addr};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic put_csr(input logic [CSR_IDX_BITS-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Wait until every request has its response, plus a short margin, so the
   // block is idle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Reprogram all three registers while idle; optionally poke the unused index.
   task automatic program_regs(input logic [31:0] base, input logic [31:0] limit,
                               input logic [31:0] hdr, input bit poke_spare);
      drain();
      put_csr(CSR_HEAP_BASE, base);
      put_csr(CSR_HEAP_LIMIT, limit);
      put_csr(CSR_HEADER_SIZE, hdr);
      if (poke_spare) put_csr(CSR_SPARE, $urandom());
      csr_valid <= 1'b0;
      @(posedge clock);
      granted_addrs.delete();
   endtask

   initial begin
      logic [31:0] size;
      logic [31:0] addr;
      int          roll;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset setting: base 0x10000, header 24,
      // limit 1 MiB. Block 0 lands at 0x10018, block 1 at 0x10031.
      issue(OP_ALLOC, 32'd0, 32'd0);              // zero size
      issue(OP_FREE, 32'd0, 32'd0);               // null free
      issue(OP_FREE, 32'd0, 32'hFFFF_FFFF);       // unknown address
      issue(OP_ALLOC, 32'd1, 32'd0);              // block 0, heap top 25
      issue(OP_ALLOC, 32'd100, 32'd0);            // block 1, heap top 149
      issue(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);      // out of memory, no overflow
      issue(OP_FREE, 32'd0, 32'd65560);           // free block 0
      issue(OP_FREE, 32'd0, 32'd65560);           // double free
      issue(OP_ALLOC, 32'd2, 32'd0);              // block 0 too small: append
      issue(OP_ALLOC, 32'd1, 32'd0);              // reuses block 0
      issue(OP_FREE, 32'd0, 32'd65585);
      issue(OP_ALLOC, 32'd100, 32'd0);            // exact size reuse of block 1
      issue(OP_FREE, 32'd0, 32'd65584);           // one below a live address
      issue(OP_ALLOC, 32'd1048377, 32'd0);        // fills the heap to the limit
      issue(OP_ALLOC, 32'd1, 32'd0);              // nothing free, no room
      issue(OP_FREE, 32'hFFFF_FFFF, 32'd65585);
      issue(OP_ALLOC, 32'd101, 32'd0);            // free block too small, no room
      issue(OP_ALLOC, 32'd50, 32'd0);             // reuse without splitting
      issue(OP_FREE, 32'd0, 32'd65585);

      // Random phases, each under its own register setting.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            // limit 1 MiB plus 4 KiB above base 0x1000, header 8
            0: program_regs(32'h0000_1000, 32'h0010_1000, 32'd8, 1'b0);
            // no base, no header, full limit: table fills up
            1: program_regs(32'h0000_0000, 32'hFFFF_FFFF, 32'd0, 1'b0);
            // addresses wrap past the top of the address space
            2: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd255, 1'b1);
            // zero limit, random base, header with junk in the upper bits
            3: program_regs($urandom(), 32'd0, $urandom(), 1'b1);
            default: begin
               quiet = 1'b1;
               program_regs(HEAP_BASE_RST, $urandom(), {24'd0, HEADER_SIZE_RST}, 1'b0);
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 1) == 0) begin
               if (roll < 8)       size = 32'd0;
               else if (roll < 75) size = $urandom_range(1, 128);
               else if (roll < 90) size = $urandom_range(129, 4096);
               else                size = $urandom();
               issue(OP_ALLOC, size, $urandom());
            end else begin
               if (granted_addrs.size() > 0 && roll < 55)
                  addr = granted_addrs[$urandom_range(0, granted_addrs.size() - 1)];
               else if (roll < 65)
                  addr = 32'd0;
               else if (granted_addrs.size() > 0 && roll < 80)
                  // near misses around a live address
                  addr = granted_addrs[$urandom_range(0, granted_addrs.size() - 1)]
                         + $urandom_range(0, 2) - 1;
               else
                  addr = $urandom();
               issue(OP_FREE, $urandom(), addr);
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ffba_pkg.sv
rtl/ffba_cell.sv
rtl/first_fit_block_allocator.sv
rtl/ffba_checker.sv
tb/ffba_checker.sv
tb/tb_first_fit_block_allocator.sv
